// ===== hdl/ils_pkg.sv =====
package ils_pkg;

  // Field widths of the request and response channels
  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_GET    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SET    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  index;
    logic [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data_out;
    logic [COUNT_W-1:0]  count;
    logic                is_full;
    logic                is_empty;
  } rsp_t;

endpackage

// ===== hdl/ils_chan_if.sv =====
interface ils_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// ===== hdl/ils_ram.sv =====
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ils_step.sv =====
// Shared address step: next source, destination of the word now read,
// and end-of-run detect for the word-by-word shift.
module ils_step #(
  parameter int AW = 6
) (
  input  logic [AW-1:0] p,
  input  logic [AW-1:0] stop,
  input  logic          down,
  output logic [AW-1:0] nxt,
  output logic [AW-1:0] dst,
  output logic          last
);

  logic [AW-1:0] p_inc;
  logic [AW-1:0] p_dec;

  assign p_inc = p + AW'(1);
  assign p_dec = p - AW'(1);

  // Insert walks down and moves each word up; remove walks up and moves down
  assign nxt  = down ? p_dec : p_inc;
  assign dst  = down ? p_inc : p_dec;
  assign last = (p == stop);

endmodule

// ===== hdl/indexed_list_store.sv =====
// Ordered list of up to DEPTH words with a fill count. Each request on req
// does get, set, append, insert or remove and gives exactly one response on
// rsp with status, the word read (old word on set, removed word on remove,
// else zero), and the count and full/empty flags after the request. Bad
// indices give status 1, append or insert on a full store status 2, and
// neither changes anything; unknown actions change nothing and report ok.
// Words live in a simple dual-port RAM with registered read; insert and
// remove move the later words one per cycle through that RAM under a small
// sequencer. Get and set read and capture the word, append writes it, and a
// rejected or unknown request goes straight to the response; insert shifts
// the later words up and then writes the new one, remove reads the word out
// and then shifts the later words down. The block takes one request at a
// time and is ready again in the cycle after the response is registered; a
// response still waiting on rsp does not block the next request.
module indexed_list_store #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  ils_chan_if.sink   req,
  ils_chan_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (ils_pkg::INDEX_W > CW) ? ils_pkg::INDEX_W : CW;
  localparam int KW = (WORD_WIDTH < ils_pkg::VALUE_W) ? WORD_WIDTH : ils_pkg::VALUE_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CAP   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                     state;
  logic [CW-1:0]                  count;
  logic [ils_pkg::ACTION_W-1:0]   act;
  logic [ils_pkg::STATUS_W-1:0]   st;
  logic [AW-1:0]                  idx;
  logic [WORD_WIDTH-1:0]          val;
  logic [ils_pkg::VALUE_W-1:0]    data;
  logic [AW-1:0]                  p;
  logic [AW-1:0]                  stop;
  logic [AW-1:0]                  wdst;
  logic                           pend;
  logic                           more;
  logic                           rsp_valid;
  ils_pkg::rsp_t                  rsp_pl;

  logic                           req_acc;
  logic [ils_pkg::STATUS_W-1:0]   req_st;
  logic [IW-1:0]                  idx_w;
  logic [IW-1:0]                  cnt_w;
  logic                           full;
  logic                           empty;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [WORD_WIDTH-1:0]          ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [WORD_WIDTH-1:0]          ram_rdata;

  logic [AW-1:0]                  st_nxt;
  logic [AW-1:0]                  st_dst;
  logic                           st_last;

  // Handshake: take a request whenever the sequencer is idle
  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_pl;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // Check the index against the count and the store against full
  always_comb begin
    idx_w  = IW'(req.payload.index);
    cnt_w  = IW'(count);
    req_st = ils_pkg::ST_OK;
    case (req.payload.action)
      ils_pkg::ACT_GET, ils_pkg::ACT_SET, ils_pkg::ACT_REMOVE: begin
        if (!(idx_w < cnt_w)) begin
          req_st = ils_pkg::ST_RANGE;
        end
      end
      ils_pkg::ACT_APPEND: begin
        if (full) begin
          req_st = ils_pkg::ST_FULL;
        end
      end
      ils_pkg::ACT_INSERT: begin
        // index check comes first, so a bad index wins over a full store
        if (idx_w > cnt_w) begin
          req_st = ils_pkg::ST_RANGE;
        end else if (full) begin
          req_st = ils_pkg::ST_FULL;
        end
      end
      default: begin
        req_st = ils_pkg::ST_OK;
      end
    endcase
  end

  ils_step #(
    .AW (AW)
  ) u_step (
    .p    (p),
    .stop (stop),
    .down (act == ils_pkg::ACT_INSERT),
    .nxt  (st_nxt),
    .dst  (st_dst),
    .last (st_last)
  );

  // RAM port steering: one read and one write a cycle at most
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = val;
    ram_raddr = p;
    case (state)
      S_RD: begin
        ram_raddr = idx;
      end
      S_CAP: begin
        // set: write the new word while the old one is captured
        ram_we = (act == ils_pkg::ACT_SET);
      end
      S_SHIFT: begin
        ram_we    = pend;
        ram_waddr = wdst;
        ram_wdata = ram_rdata;
      end
      S_DRAIN: begin
        ram_we    = 1'b1;
        ram_waddr = wdst;
        ram_wdata = ram_rdata;
      end
      S_WR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ils_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // drop the response once taken, unless a fresh one is loaded below
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            act  <= req.payload.action;
            st   <= req_st;
            // append writes at the end of the list; the rest use the index
            idx  <= (req.payload.action == ils_pkg::ACT_APPEND) ? AW'(count) :
                    AW'(req.payload.index);
            val  <= WORD_WIDTH'(req.payload.value[KW-1:0]);
            data <= '0;
            pend <= 1'b0;
            // only a remove looks at this: are there words above the hole
            more <= (idx_w < cnt_w - IW'(1));
            if (req_st != ils_pkg::ST_OK) begin
              state <= S_DONE;
            end else begin
              case (req.payload.action)
                ils_pkg::ACT_GET, ils_pkg::ACT_SET: begin
                  state <= S_RD;
                end
                ils_pkg::ACT_APPEND: begin
                  count <= count + CW'(1);
                  state <= S_WR;
                end
                ils_pkg::ACT_INSERT: begin
                  // walk down from the last word to the insert point
                  count <= count + CW'(1);
                  p     <= AW'(count - CW'(1));
                  stop  <= AW'(req.payload.index);
                  state <= (idx_w == cnt_w) ? S_WR : S_SHIFT;
                end
                ils_pkg::ACT_REMOVE: begin
                  // walk up from the word after the hole to the last word
                  count <= count - CW'(1);
                  p     <= AW'(req.payload.index) + AW'(1);
                  stop  <= AW'(count - CW'(1));
                  state <= S_RD;
                end
                default: begin
                  state <= S_DONE;
                end
              endcase
            end
          end
        end
        S_RD: begin
          state <= S_CAP;
        end
        S_CAP: begin
          data  <= ils_pkg::VALUE_W'(ram_rdata[KW-1:0]);
          state <= (act == ils_pkg::ACT_REMOVE && more) ? S_SHIFT : S_DONE;
        end
        S_SHIFT: begin
          // read one word a cycle; each word is written back from the registered RAM read
          pend <= 1'b1;
          wdst <= st_dst;
          p    <= st_nxt;
          if (st_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          pend  <= 1'b0;
          state <= (act == ils_pkg::ACT_INSERT) ? S_WR : S_DONE;
        end
        S_WR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid       <= 1'b1;
            rsp_pl.status   <= st;
            rsp_pl.data_out <= data;
            rsp_pl.count    <= ils_pkg::COUNT_W'(count);
            rsp_pl.is_full  <= full;
            rsp_pl.is_empty <= empty;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_shift_no_clash: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && pend) |-> (wdst != p))
    else $error("shift writes the word it reads");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req_st == ils_pkg::ST_OK && req.payload.action == ils_pkg::ACT_APPEND)
      |=> (count == $past(count) + CW'(1)))
    else $error("append did not advance the count");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!rsp_valid || rsp.ready)) |=> (rsp_valid && state == S_IDLE))
    else $error("finished request not presented");

endmodule

// ===== test/tb_indexed_list_store.sv =====
module tb_indexed_list_store;
  import ils_pkg::*;

  localparam int DEPTH       = 64;
  localparam int WORD_WIDTH  = 32;
  // Chance in a hundred that either side idles in a given cycle
  localparam int IDLE_PCT    = 24;
  // Longest request is a remove at the front of a full store; the tail wait
  // covers it
  localparam int TAIL_CYCLES = DEPTH + 8;

  // Which way a run of random requests pushes the fill level
  typedef enum int {DRIFT_GROW, DRIFT_SHRINK, DRIFT_HOLD} drift_t;

  logic clk = 1'b0;
  logic rst;

  ils_chan_if #(.T(req_t)) req_if ();
  ils_chan_if #(.T(rsp_t)) rsp_if ();

  // Shadow copy of the list, updated as each request is accepted
  logic [WORD_WIDTH-1:0] shadow_words [DEPTH];
  int unsigned           shadow_fill = 0;

  // Responses still owed by the block, oldest first
  rsp_t        pending_rsp [$];
  int unsigned mismatches = 0;
  // Set during the back-to-back run: neither side idles
  bit          no_idle = 1'b0;

  indexed_list_store #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #5 clk = ~clk;

  // Apply one request to the shadow list and work out the response it earns.
  // Range check comes before the full check on insert, so a bad index wins
  // even on a full store. Unknown actions leave everything alone and report ok.
  function automatic rsp_t apply_list_op(req_t r);
    rsp_t                  res;
    int unsigned           idx;
    int unsigned           i;
    logic [WORD_WIDTH-1:0] word;
    res  = '0;
    idx  = r.index;
    word = r.value[WORD_WIDTH-1:0];
    case (r.action)
      ACT_GET: begin
        if (idx < shadow_fill) res.data_out = shadow_words[idx];
        else res.status = ST_RANGE;
      end
      ACT_SET: begin
        if (idx < shadow_fill) begin
          res.data_out      = shadow_words[idx];
          shadow_words[idx] = word;
        end else begin
          res.status = ST_RANGE;
        end
      end
      ACT_APPEND: begin
        if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_words[shadow_fill] = word;
          shadow_fill++;
        end
      end
      ACT_INSERT: begin
        if (idx > shadow_fill) begin
          res.status = ST_RANGE;
        end else if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // shift the tail up by one, top first
          for (i = shadow_fill; i > idx; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[idx] = word;
          shadow_fill++;
        end
      end
      ACT_REMOVE: begin
        if (idx < shadow_fill) begin
          res.data_out = shadow_words[idx];
          // close the gap, bottom first
          for (i = idx; i + 1 < shadow_fill; i++) shadow_words[i] = shadow_words[i+1];
          shadow_fill--;
        end else begin
          res.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    res.count    = COUNT_W'(shadow_fill);
    res.is_full  = (shadow_fill >= DEPTH);
    res.is_empty = (shadow_fill == 0);
    return res;
  endfunction

  // Data word with a bias towards all zeros and all ones
  function automatic logic [VALUE_W-1:0] random_word();
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Draw one random request. Most indices are legal for the current fill so
  // that the list really moves; the rest land anywhere in 0..DEPTH and hit
  // the range check. A trickle of unknown actions goes in too.
  function automatic req_t pick_request(drift_t drift);
    req_t        r;
    int unsigned roll;
    int unsigned grow_pct;
    int unsigned shrink_pct;
    case (drift)
      DRIFT_GROW:   begin grow_pct = 55; shrink_pct = 10; end
      DRIFT_SHRINK: begin grow_pct = 10; shrink_pct = 50; end
      default:      begin grow_pct = 30; shrink_pct = 30; end
    endcase
    r.value = random_word();
    roll    = $urandom_range(99);
    if (roll < 2) r.action = ACTION_W'($urandom_range(2**ACTION_W - 1, ACT_REMOVE + 1));
    else if (roll < 2 + grow_pct) r.action = $urandom_range(1) ? ACT_APPEND : ACT_INSERT;
    else if (roll < 2 + grow_pct + shrink_pct) r.action = ACT_REMOVE;
    else r.action = $urandom_range(1) ? ACT_GET : ACT_SET;
    if ($urandom_range(99) < 12) r.index = INDEX_W'($urandom_range(DEPTH));
    else if (r.action == ACT_INSERT) r.index = INDEX_W'($urandom_range(shadow_fill));
    else if (shadow_fill > 0) r.index = INDEX_W'($urandom_range(shadow_fill - 1));
    else r.index = '0;
    return r;
  endfunction

  // Offer one request, starting at a falling edge, and return at the falling
  // edge after it was taken. Valid is left high: the next call either idles
  // it low or replaces the payload, and wait_for_responses drops it.
  task automatic send_request(input req_t r);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.payload = r;
    req_if.valid   = 1'b1;
    do @(posedge clk); while (!req_if.ready);
    // accepted at this edge: predict now, in acceptance order
    pending_rsp.push_back(apply_list_op(r));
    @(negedge clk);
  endtask

  task automatic send_op(input logic [ACTION_W-1:0] action, input int unsigned idx,
                         input logic [VALUE_W-1:0] value);
    req_t r;
    r.action = action;
    r.index  = INDEX_W'(idx);
    r.value  = value;
    send_request(r);
  endtask

  // Drop valid and hold until every owed response has come back
  task automatic wait_for_responses();
    req_if.valid = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  // Hand-picked requests on a short list: every action on the empty store,
  // unknown actions, inserts at the front, at the tail and past it, reads at
  // and beyond the count, removes at both ends, then drain back to empty.
  task automatic test_directed_cases();
    int a;
    send_op(ACT_GET, 0, '0);
    send_op(ACT_REMOVE, 0, '0);
    send_op(ACT_SET, 0, 32'hDEAD_BEEF);
    send_op(ACT_INSERT, 1, 32'h0000_0001);
    for (a = ACT_REMOVE + 1; a < 2**ACTION_W; a++) send_op(ACTION_W'(a), 0, '1);
    // append ignores the index, so use it to raise the top index bit
    send_op(ACT_APPEND, DEPTH, '0);
    send_op(ACT_APPEND, 0, '1);
    send_op(ACT_INSERT, 0, 32'hA5A5_A5A5);
    send_op(ACT_INSERT, 3, 32'h5A5A_5A5A);
    send_op(ACT_INSERT, 5, 32'h0000_0001);
    send_op(ACT_GET, 0, '0);
    send_op(ACT_GET, 3, '0);
    send_op(ACT_GET, 4, '0);
    send_op(ACT_GET, DEPTH, '0);
    send_op(ACT_SET, 1, 32'h1234_5678);
    send_op(ACT_REMOVE, 0, '0);
    send_op(ACT_REMOVE, 2, '0);
    send_op(ACT_REMOVE, 2, '0);
    send_op(ACTION_W'(ACT_REMOVE + 3), 1, '1);
    send_op(ACT_REMOVE, 0, '0);
    send_op(ACT_REMOVE, 0, '0);
    wait_for_responses();
  endtask

  // Fill the store with random words, then poke at it while full: append and
  // insert must report full, the longest shifts go both ways, and the top
  // slot is read, overwritten and removed.
  task automatic test_fill_and_overflow();
    while (shadow_fill < DEPTH - 1) begin
      if ($urandom_range(1)) send_op(ACT_APPEND, $urandom_range(DEPTH), random_word());
      else send_op(ACT_INSERT, $urandom_range(shadow_fill), random_word());
    end
    send_op(ACT_INSERT, 0, random_word());
    send_op(ACT_APPEND, 0, random_word());
    send_op(ACT_INSERT, 0, random_word());
    send_op(ACT_INSERT, DEPTH, random_word());
    send_op(ACT_GET, DEPTH, '0);
    send_op(ACT_GET, DEPTH - 1, '0);
    send_op(ACT_SET, DEPTH - 1, random_word());
    send_op(ACT_REMOVE, 0, '0);
    send_op(ACT_INSERT, DEPTH - 1, random_word());
    send_op(ACT_REMOVE, DEPTH - 1, '0);
    wait_for_responses();
  endtask

  // Both sides flat out: no idle requests and the receiver never stalls
  task automatic test_back_to_back(input int unsigned total);
    no_idle = 1'b1;
    repeat (total) send_request(pick_request(drift_t'($urandom_range(DRIFT_HOLD))));
    wait_for_responses();
    no_idle = 1'b0;
  endtask

  // Runs of random requests, each run pushing the fill up, down or holding
  // it, so the store swings between empty and full many times over
  task automatic test_random_mix(input int unsigned total);
    int unsigned sent;
    drift_t      drift;
    sent = 0;
    while (sent < total) begin
      drift = drift_t'($urandom_range(DRIFT_HOLD));
      repeat ($urandom_range(160, 40)) begin
        send_request(pick_request(drift));
        sent++;
      end
    end
    wait_for_responses();
  endtask

  // Receiver: stall at random, except during the back-to-back run
  always @(negedge clk) begin
    rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each response taken with the oldest one owed
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    rsp_t got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.payload;
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding: status %0d data_out %h",
               got.status, got.data_out);
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
        if (got.data_out !== want.data_out) begin
          $error("data_out: expected %h, got %h", want.data_out, got.data_out);
          mismatches++;
        end
        if (got.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, got.count);
          mismatches++;
        end
        if (got.is_full !== want.is_full) begin
          $error("is_full: expected %0b, got %0b", want.is_full, got.is_full);
          mismatches++;
        end
        if (got.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst            = 1'b1;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_fill_and_overflow();
    test_back_to_back(200);
    test_random_mix(1250);

    // let any stray response show itself before closing
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog: a correct run needs well under a fifth of this
  initial begin
    #6_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
